/* rtl/core/q2e_pkg.sv */
// q2e_pkg: shared types, widths, constants and the arctangent table
// for the quaternion to euler angle core; no dependencies
`default_nettype none
package q2e_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int SQRT_STAGES   = 29;
   localparam int IN_W          = 16;
   localparam int PROD_W        = 32;
   localparam int SUM_W         = 34;
   localparam int CW            = 36;
   localparam int D_W           = 57;
   localparam int IDX_W         = 5;

   localparam logic signed [CW-1:0]    HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [SUM_W-1:0] ONE_Q28     = 34'sd268435456;
   localparam logic signed [CW-1:0]    ROUND_Q30   = 36'sd65536;
   localparam logic signed [15:0]      PI_Q13      = 16'sd25736;
   localparam logic signed [15:0]      HALF_PI_Q13 = 16'sd12868;

   typedef logic signed [CW-1:0]    cval_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   typedef struct packed {
      cval_type x;
      cval_type y;
      cval_type z;
      logic     zero;
   } lane_type;

   typedef struct packed {
      logic [D_W-1:0] rem;
      logic [D_W-1:0] root;
   } root_type;

   typedef struct packed {
      sum_type sr;
      sum_type cr;
      sum_type sy;
      sum_type cy;
      sum_type sp;
      logic    clamp;
   } side_type;

   // atan(2^-i) in q30, truncated; entries 27 to 30 are rounded
   function automatic cval_type atan_q30(input logic [IDX_W-1:0] i);
      cval_type t;
      case (i)
         5'd0:  t = 36'sd843314856;
         5'd1:  t = 36'sd497837829;
         5'd2:  t = 36'sd263043836;
         5'd3:  t = 36'sd133525158;
         5'd4:  t = 36'sd67021686;
         5'd5:  t = 36'sd33543515;
         5'd6:  t = 36'sd16775850;
         5'd7:  t = 36'sd8388437;
         5'd8:  t = 36'sd4194282;
         5'd9:  t = 36'sd2097149;
         5'd10: t = 36'sd1048575;
         5'd11: t = 36'sd524287;
         5'd12: t = 36'sd262143;
         5'd13: t = 36'sd131071;
         5'd14: t = 36'sd65535;
         5'd15: t = 36'sd32767;
         5'd16: t = 36'sd16383;
         5'd17: t = 36'sd8191;
         5'd18: t = 36'sd4095;
         5'd19: t = 36'sd2047;
         5'd20: t = 36'sd1023;
         5'd21: t = 36'sd511;
         5'd22: t = 36'sd255;
         5'd23: t = 36'sd127;
         5'd24: t = 36'sd63;
         5'd25: t = 36'sd31;
         5'd26: t = 36'sd15;
         5'd27: t = 36'sd8;
         5'd28: t = 36'sd4;
         5'd29: t = 36'sd2;
         5'd30: t = 36'sd1;
         default: t = 36'sd0;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/q2e_sqrt_cell.sv */
// q2e_sqrt_cell: one stage of the integer square root recurrence
// depends on q2e_pkg
`default_nettype none
module q2e_sqrt_cell (
   input  wire logic                       clock,
   input  wire logic [q2e_pkg::IDX_W-1:0]  stage_idx,
   input  wire q2e_pkg::root_type          root_in,
   output q2e_pkg::root_type               root_ff
);
   import q2e_pkg::*;

   logic [D_W-1:0] bit_val;
   logic [D_W:0]   trial;
   root_type       root_in_next;

   always_comb begin
      bit_val = D_W'(1) << (6'd56 - {stage_idx, 1'b0});
      trial   = {1'b0, root_in.root} + {1'b0, bit_val};
      if ({1'b0, root_in.rem} >= trial) begin
         root_in_next.rem  = D_W'({1'b0, root_in.rem} - trial);
         root_in_next.root = (root_in.root >> 1) + bit_val;
      end else begin
         root_in_next.rem  = root_in.rem;
         root_in_next.root = root_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in_next;
   end
endmodule
`default_nettype wire

/* rtl/core/q2e_cordic_cell.sv */
// q2e_cordic_cell: one vectoring cordic micro-rotation for one angle lane
// depends on q2e_pkg
`default_nettype none
module q2e_cordic_cell (
   input  wire logic                       clock,
   input  wire logic [q2e_pkg::IDX_W-1:0]  stage_idx,
   input  wire q2e_pkg::lane_type          lane_in,
   output q2e_pkg::lane_type               lane_ff
);
   import q2e_pkg::*;

   cval_type dx;
   cval_type dy;
   cval_type t;
   lane_type lane_in_next;

   always_comb begin
      dx = lane_in.y >>> stage_idx;
      dy = lane_in.x >>> stage_idx;
      t  = atan_q30(stage_idx);
      lane_in_next.zero = lane_in.zero;
      if (!lane_in.y[CW-1]) begin
         lane_in_next.x = lane_in.x + dx;
         lane_in_next.y = lane_in.y - dy;
         lane_in_next.z = lane_in.z + t;
      end else begin
         lane_in_next.x = lane_in.x - dx;
         lane_in_next.y = lane_in.y + dy;
         lane_in_next.z = lane_in.z - t;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in_next;
   end
endmodule
`default_nettype wire

/* rtl/core/quaternion_to_euler_angles_core.sv */
// quaternion_to_euler_angles_core: top level, quaternion q2.14 in, roll/yaw q3.13 and pitch q2.13 out
// depends on q2e_pkg, q2e_sqrt_cell, q2e_cordic_cell
//
// fully pipelined: a request is taken in every cycle (busy is always low); its
// result passes the product, sum, radicand, square root, prerotation, cordic and
// output registers, marked by rsp_valid for one cycle; the receiver cannot stall,
// so results must be taken as they come. the latency is set by the 29-cell square
// root chain for the pitch cosine followed by the 16-cell cordic chain; roll and
// yaw travel alongside in delay registers. pitch_clamped flags |sin pitch| >= 1
`default_nettype none
module quaternion_to_euler_angles_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic signed [15:0]  req_quat_w,
   input  wire logic signed [15:0]  req_quat_x,
   input  wire logic signed [15:0]  req_quat_y,
   input  wire logic signed [15:0]  req_quat_z,
   output logic                     rsp_valid,
   output logic signed [15:0]       rsp_roll_angle,
   output logic signed [14:0]       rsp_pitch_angle,
   output logic signed [15:0]       rsp_yaw_angle,
   output logic                     rsp_pitch_clamped
);
   import q2e_pkg::*;

   // valid flags: products, sums, root setup, sqrt cells, prerotate, cordic cells
   localparam int LAT = 3 + SQRT_STAGES + 1 + CORDIC_STAGES;

   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   // stage 1: products
   logic signed [PROD_W-1:0] wx_ff, yz_ff, wz_ff, xy_ff, wy_ff, zx_ff, xx_ff, yy_ff, zz_ff;
   // stage 2: sums
   side_type sum_ff;
   side_type sum_in;
   // stage 3: square of the pitch sine and radicand
   side_type  s3_ff;
   root_type  root0_ff;
   logic [27:0] sp_mag;
   logic [55:0] sp_sq;

   root_type root_chain [SQRT_STAGES+1];
   side_type side_ff    [SQRT_STAGES];

   lane_type lane_roll  [CORDIC_STAGES+1];
   lane_type lane_pitch [CORDIC_STAGES+1];
   lane_type lane_yaw   [CORDIC_STAGES+1];
   logic [1:0] flag_ff  [CORDIC_STAGES+1];  // {clamp, sine negative}

   // x < 0 is first turned into the right half plane
   function automatic lane_type prerot(input cval_type y, input cval_type x);
      lane_type l;
      l.zero = (x == '0) && (y == '0);
      if (x[CW-1]) begin
         if (!y[CW-1]) begin
            l.x = y;
            l.y = -x;
            l.z = HALF_PI_Q30;
         end else begin
            l.x = -y;
            l.y = x;
            l.z = -HALF_PI_Q30;
         end
      end else begin
         l.x = x;
         l.y = y;
         l.z = '0;
      end
      return l;
   endfunction

   // q30 to rounded q13, then held to +-lim
   function automatic logic signed [15:0] to_q13(input lane_type l,
                                                 input logic signed [15:0] lim);
      cval_type r;
      cval_type q;
      cval_type lw;
      logic signed [15:0] o;
      r  = l.z + ROUND_Q30;
      q  = r >>> 17;
      lw = CW'(lim);
      if (l.zero)
         o = '0;
      else if (q > lw)
         o = lim;
      else if (q < -lw)
         o = -lim;
      else
         o = q[15:0];
      return o;
   endfunction

   assign busy = 1'b0;

   // valid shift line
   always_comb begin
      vld_in = {vld_ff[LAT-2:0], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rsp_valid <= vld_ff[LAT-1];
      end
   end

   // products
   always_ff @(posedge clock) begin
      wx_ff <= req_quat_w * req_quat_x;
      yz_ff <= req_quat_y * req_quat_z;
      wz_ff <= req_quat_w * req_quat_z;
      xy_ff <= req_quat_x * req_quat_y;
      wy_ff <= req_quat_w * req_quat_y;
      zx_ff <= req_quat_z * req_quat_x;
      xx_ff <= req_quat_x * req_quat_x;
      yy_ff <= req_quat_y * req_quat_y;
      zz_ff <= req_quat_z * req_quat_z;
   end

   // product sums, all in q28
   always_comb begin
      sum_in.sr = (SUM_W'(wx_ff) + SUM_W'(yz_ff)) <<< 1;
      sum_in.cr = ONE_Q28 - ((SUM_W'(xx_ff) + SUM_W'(yy_ff)) <<< 1);
      sum_in.sy = (SUM_W'(wz_ff) + SUM_W'(xy_ff)) <<< 1;
      sum_in.cy = ONE_Q28 - ((SUM_W'(yy_ff) + SUM_W'(zz_ff)) <<< 1);
      sum_in.sp = (SUM_W'(wy_ff) - SUM_W'(zx_ff)) <<< 1;
      sum_in.clamp = (sum_in.sp >= ONE_Q28) || (sum_in.sp <= -ONE_Q28);
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // radicand 1 - s*s in q56; only meaningful when not clamped
   always_comb begin
      sp_mag = sum_ff.sp[SUM_W-1] ? 28'(-sum_ff.sp) : sum_ff.sp[27:0];
      sp_sq  = sp_mag * sp_mag;
   end

   always_ff @(posedge clock) begin
      s3_ff         <= sum_ff;
      root0_ff.rem  <= {1'b1, 56'd0} - {1'b0, sp_sq};
      root0_ff.root <= '0;
   end

   assign root_chain[0] = root0_ff;

   // square root chain, sums ride along
   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
      q2e_sqrt_cell u_cell (
         .clock     (clock),
         .stage_idx (IDX_W'(i)),
         .root_in   (root_chain[i]),
         .root_ff   (root_chain[i+1])
      );
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            side_ff[i] <= s3_ff;
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // quadrant prerotation for the three atan2 lanes
   always_ff @(posedge clock) begin
      lane_roll[0]  <= prerot(CW'(side_ff[SQRT_STAGES-1].sr), CW'(side_ff[SQRT_STAGES-1].cr));
      lane_yaw[0]   <= prerot(CW'(side_ff[SQRT_STAGES-1].sy), CW'(side_ff[SQRT_STAGES-1].cy));
      lane_pitch[0] <= prerot(CW'(side_ff[SQRT_STAGES-1].sp),
                              CW'(root_chain[SQRT_STAGES].root));
      flag_ff[0]    <= {side_ff[SQRT_STAGES-1].clamp, side_ff[SQRT_STAGES-1].sp[SUM_W-1]};
   end

   // cordic chain
   for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
      q2e_cordic_cell u_roll (
         .clock     (clock),
         .stage_idx (IDX_W'(j)),
         .lane_in   (lane_roll[j]),
         .lane_ff   (lane_roll[j+1])
      );
      q2e_cordic_cell u_pitch (
         .clock     (clock),
         .stage_idx (IDX_W'(j)),
         .lane_in   (lane_pitch[j]),
         .lane_ff   (lane_pitch[j+1])
      );
      q2e_cordic_cell u_yaw (
         .clock     (clock),
         .stage_idx (IDX_W'(j)),
         .lane_in   (lane_yaw[j]),
         .lane_ff   (lane_yaw[j+1])
      );
      always_ff @(posedge clock) begin
         flag_ff[j+1] <= flag_ff[j];
      end
   end

   // rounding, saturation and clamp override
   logic signed [15:0] pitch_full;

   always_comb begin
      if (flag_ff[CORDIC_STAGES][1])
         pitch_full = flag_ff[CORDIC_STAGES][0] ? -HALF_PI_Q13 : HALF_PI_Q13;
      else
         pitch_full = to_q13(lane_pitch[CORDIC_STAGES], HALF_PI_Q13);
   end

   always_ff @(posedge clock) begin
      rsp_roll_angle    <= to_q13(lane_roll[CORDIC_STAGES], PI_Q13);
      rsp_yaw_angle     <= to_q13(lane_yaw[CORDIC_STAGES], PI_Q13);
      rsp_pitch_angle   <= pitch_full[14:0];
      rsp_pitch_clamped <= flag_ff[CORDIC_STAGES][1];
   end
endmodule
`default_nettype wire
